// ===== sv/wbsc_pkg.sv =====
package wbsc_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [1:0] ACT_WRITEBACK = 2'd0;
    localparam logic [1:0] ACT_FILL      = 2'd1;
    localparam logic [1:0] ACT_DONE      = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  device_id;
        logic [47:0] sector_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  entry_index;
        logic [7:0]  out_device;
        logic [47:0] out_sector;
        logic        last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic emit_wb;
        logic emit_fill;
        logic walk;
        logic emit_done;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       hit;
        logic       wb_need;
        logic       walk_last;
    } t_stat;

endpackage

// ===== sv/wbsc_ctrl.sv =====
module wbsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  wbsc_pkg::t_stat i_stat,
    output logic           o_busy,
    output wbsc_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOK  = 6'b000010,
        S_WB    = 6'b000100,
        S_FILL  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rw_mode;

    assign rw_mode = (i_stat.mode == wbsc_pkg::MODE_READ) ||
                     (i_stat.mode == wbsc_pkg::MODE_WRITE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                if (i_stat.mode == wbsc_pkg::MODE_FLUSH) begin
                    n_state = S_FLUSH;
                end else if (!rw_mode || i_stat.hit) begin
                    n_state = S_DONE;
                end else if (i_stat.wb_need) begin
                    n_state = S_WB;
                end else if (i_stat.mode == wbsc_pkg::MODE_READ) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WB: begin
                o_cmd.emit_wb = 1'b1;
                n_state = (i_stat.mode == wbsc_pkg::MODE_READ) ? S_FILL : S_DONE;
            end
            S_FILL: begin
                o_cmd.emit_fill = 1'b1;
                n_state         = S_DONE;
            end
            S_FLUSH: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit_done = 1'b1;
                o_cmd.commit    = rw_mode;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/wbsc_dp.sv =====
module wbsc_dp #(
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wbsc_pkg::t_req  i_req,
    input  wbsc_pkg::t_cmd  i_cmd,
    output wbsc_pkg::t_stat o_stat,
    output logic            o_strobe,
    output wbsc_pkg::t_res  o_result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    wbsc_pkg::t_req r_req;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_dirty;
    logic [ENTRIES-1:0] r_used;
    logic [47:0]        r_sec_tag [ENTRIES];
    logic [7:0]         r_dev_tag [ENTRIES];
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_cnt;
    logic               r_hit;
    logic               r_allused;
    logic               r_strobe;
    wbsc_pkg::t_res     r_out;

    logic               n_strobe;
    wbsc_pkg::t_res     n_out;

    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [IW-1:0]      hit_idx;
    logic               any_free;
    logic [IW-1:0]      free_idx;
    logic               any_unused;
    logic [IW-1:0]      unused_idx;
    logic [IW-1:0]      vic_idx;
    logic               all_used;
    logic [IW-1:0]      rd_idx;
    logic               walk_hit;
    logic               rw_mode;
    logic               is_write;
    logic [IW+3:0]      idx_ext;
    logic [IW+3:0]      cnt_ext;

    // parallel tag compare and lowest-index searches
    always_comb begin
        match      = '0;
        hit_idx    = '0;
        free_idx   = '0;
        unused_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_dev_tag[i] == r_req.device_id) &&
                       (r_sec_tag[i] == r_req.sector_address);
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
            if (!r_used[i]) begin
                unused_idx = IW'(i);
            end
        end
    end

    assign hit        = |match;
    assign any_free   = ~&r_valid;
    assign any_unused = ~&r_used;
    assign all_used   = !any_free && !any_unused;
    assign vic_idx    = any_free ? free_idx : (any_unused ? unused_idx : '0);

    assign o_stat.mode      = r_req.mode;
    assign o_stat.hit       = hit;
    assign o_stat.wb_need   = r_valid[vic_idx] && r_dirty[vic_idx];
    assign o_stat.walk_last = (r_cnt == IW'(ENTRIES - 1));

    assign rw_mode  = (r_req.mode == wbsc_pkg::MODE_READ) ||
                      (r_req.mode == wbsc_pkg::MODE_WRITE);
    assign is_write = (r_req.mode == wbsc_pkg::MODE_WRITE);
    assign rd_idx   = i_cmd.walk ? r_cnt : r_idx;
    assign walk_hit = r_valid[r_cnt] && r_dirty[r_cnt] &&
                      (r_dev_tag[r_cnt] == r_req.device_id);
    assign idx_ext  = {4'b0, r_idx};
    assign cnt_ext  = {4'b0, r_cnt};

    // request and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_cnt <= '0;
        end
        if (i_cmd.walk) begin
            r_cnt <= r_cnt + IW'(1);
        end
        if (i_cmd.lookup) begin
            r_hit     <= hit;
            r_idx     <= hit ? hit_idx : vic_idx;
            r_allused <= all_used;
        end
    end

    // status bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_used  <= '0;
        end else begin
            if (i_cmd.emit_wb) begin
                r_dirty[r_idx] <= 1'b0;
            end
            if (i_cmd.walk && walk_hit) begin
                r_dirty[r_cnt] <= 1'b0;
            end
            if (i_cmd.commit) begin
                // all used: every used bit clears and only the victim keeps one
                if (!r_hit && r_allused) begin
                    r_used <= ENTRIES'(1) << r_idx;
                end else begin
                    r_used[r_idx] <= 1'b1;
                end
                r_valid[r_idx] <= 1'b1;
                if (is_write) begin
                    r_dirty[r_idx] <= 1'b1;
                end else if (!r_hit) begin
                    r_dirty[r_idx] <= 1'b0;
                end
            end
        end
    end

    // tags of a new entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_hit) begin
            r_sec_tag[r_idx] <= r_req.sector_address;
            r_dev_tag[r_idx] <= r_req.device_id;
        end
    end

    always_comb begin
        n_strobe = 1'b0;
        n_out    = '0;
        if (i_cmd.emit_wb || (i_cmd.walk && walk_hit)) begin
            n_strobe          = 1'b1;
            n_out.action      = wbsc_pkg::ACT_WRITEBACK;
            n_out.entry_index = i_cmd.walk ? cnt_ext[3:0] : idx_ext[3:0];
            n_out.out_device  = r_dev_tag[rd_idx];
            n_out.out_sector  = r_sec_tag[rd_idx];
        end else if (i_cmd.emit_fill) begin
            n_strobe          = 1'b1;
            n_out.action      = wbsc_pkg::ACT_FILL;
            n_out.entry_index = idx_ext[3:0];
            n_out.out_device  = r_req.device_id;
            n_out.out_sector  = r_req.sector_address;
        end else if (i_cmd.emit_done) begin
            n_strobe          = 1'b1;
            n_out.action      = wbsc_pkg::ACT_DONE;
            n_out.entry_index = rw_mode ? idx_ext[3:0] : 4'd0;
            n_out.out_device  = r_req.device_id;
            n_out.out_sector  = rw_mode ? r_req.sector_address : 48'd0;
            n_out.last        = 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ===== sv/write_back_sector_cache_controller_unit.sv =====
// tag and policy controller of a fully associative write-back sector cache
// with second-chance replacement.
// request channel: i_req (mode, device, sector) is taken at a clock edge
// with start high and busy low; busy stays high until the run is over.
// result channel: each result beat sits on o_result for one cycle with
// o_strobe high; the receiver cannot stall, so every beat is final.
// each request yields its commands (writeback, fill) in order and ends
// with one completion beat that has last set.
// sequence: a lookup state (parallel tag compare and victim search),
// then one state per command and a completion state; a flush walks
// one entry per cycle. the result register delays each beat into the
// cycle after its state: the completion beat comes in the first cycle
// with busy low and a new request can be taken at the edge ending it.
// reset clears valid, dirty and used bits at once; there is no clearing
// pass and the block is ready in the first cycle after reset.
module write_back_sector_cache_controller_unit #(
    parameter int ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  wbsc_pkg::t_req i_req,
    output logic           o_strobe,
    output wbsc_pkg::t_res o_result
);

    wbsc_pkg::t_cmd  cmd;
    wbsc_pkg::t_stat stat;

    wbsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    wbsc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
